// ===== src/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants of the suffix array / LCP builder
// Holds the sequencer state type, the function and result kind codes and the
// default sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 256;

  // function selector on the input channel
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // result kinds on the output channel
  localparam logic [1:0] KIND_BUILT = 2'd0;
  localparam logic [1:0] KIND_TRUNC = 2'd1;
  localparam logic [1:0] KIND_RANK  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TERM, ST_CLR, ST_HA, ST_HB, ST_HC, ST_PSA, ST_PSB,
    ST_SCA, ST_SCB, ST_SCC, ST_RND, ST_Y1, ST_Y2A, ST_Y2B,
    ST_WVA, ST_WVB, ST_WVC, ST_RKA, ST_RKB, ST_RKC, ST_RKD,
    ST_INVA, ST_INVB, ST_LKA, ST_LKB, ST_LKC, ST_LKD,
    ST_DONE, ST_RDA, ST_RDB
  } sal_state_t;

endpackage

`default_nettype wire

// ===== src/sal_ram.sv =====
// ----------------------------------------------------------------------------
// sal_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [DW-1:0]            wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [DW-1:0]            rd
);

  logic [DW-1:0] mem [DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

// ===== src/suffix_array_lcp_builder.sv =====
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder: suffix array by prefix doubling plus Kasai LCP
//
// Input channel s_*: tuser is func. A load item (func 0) is written straight
// into the text store; the load with tlast set appends the terminator and
// starts the build. A read item (func 1) passes ST_RDA, then ST_RDB, which
// puts its result in the output register once that is free; s_tready returns
// with ST_IDLE, so each read is answered before the next item is taken.
// The build runs one sequencer over RAMs with a single read port each: the
// initial symbol sort, up to ceil(log2(n+1)) doubling rounds, then the
// inverse and Kasai passes. s_tready is low for the whole build.
// Output channel m_*: tuser is the kind; one result register holds an item
// until it is taken, and the block waits with the next result while the
// receiver stalls. Reset clears the symbol count and the built flag; the
// RAMs are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_array_lcp_builder
  import sal_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // symbol[7:0], rank[18:8], zero pad
  input  wire logic        s_tuser,   // func
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // suffix_start[9:0], lcp_length[19:10],
                                      // text_length[30:20], zero pad
  output logic      [1:0]  m_tuser    // kind
);

  localparam int DEPTH = MAX_LEN + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int BD    = (ALPHABET > DEPTH) ? ALPHABET : DEPTH;
  localparam int BAW   = $clog2(BD);
  localparam int CW    = $clog2(BD + 1) + 1;
  localparam int WCW   = $clog2(DEPTH + 1);
  localparam int RCW   = (CW > 11) ? CW : 11;

  // registers
  sal_state_t       state, state_next;
  logic [AW-1:0]    cnt, cnt_next;
  logic             dropped, dropped_next;
  logic             built, built_next;
  logic [CW-1:0]    i, i_next;
  logic [CW-1:0]    p, p_next;
  logic [CW-1:0]    m, m_next;
  logic [CW-1:0]    j, j_next;
  logic [CW-1:0]    k, k_next;
  logic             cur, cur_next;
  logic             rnd, rnd_next;
  logic [WCW-1:0]   acc, acc_next;
  logic [BAW-1:0]   key, key_next;
  logic [AW-1:0]    val, val_next;
  logic [AW-1:0]    b, b_next;
  logic [BAW-1:0]   yb, yb_next;
  logic [BAW-1:0]   ya, ya_next;
  logic [BAW-1:0]   yaj, yaj_next;
  logic             ain, ain_next;
  logic             bin, bin_next;
  logic [AW-1:0]    q, q_next;
  logic [AW-1:0]    invi, invi_next;
  logic [10:0]      rank_r, rank_r_next;
  logic             ovalid, ovalid_next;
  logic [1:0]       okind, okind_next;
  logic [9:0]       ostart, ostart_next;
  logic [9:0]       olcp, olcp_next;
  logic [10:0]      olen, olen_next;

  // RAM ports
  logic             tx_we;
  logic [AW-1:0]    tx_wa, tx_ra, tx2_ra;
  logic [7:0]       tx_wd, tx_rd, tx2_rd;
  logic             sa_we;
  logic [AW-1:0]    sa_wa, sa_ra, sa_wd, sa_rd;
  logic [1:0]       rk_we;
  logic [AW-1:0]    rk_wa [2];
  logic [AW-1:0]    rk_ra [2];
  logic [BAW-1:0]   rk_wd [2];
  logic [BAW-1:0]   rk_rd [2];
  logic             wv_we;
  logic [AW-1:0]    wv_wa, wv_ra;
  logic [BAW-1:0]   wv_wd, wv_rd;
  logic             wc_we;
  logic [BAW-1:0]   wc_wa, wc_ra;
  logic [WCW-1:0]   wc_wd, wc_rd;
  logic             inv_we;
  logic [AW-1:0]    inv_wa, inv_ra, inv_wd, inv_rd;
  logic             lcp_we;
  logic [AW-1:0]    lcp_wa, lcp_ra, lcp_wd, lcp_rd;

  // decoded input and helpers
  logic             fire, ofree;
  logic [7:0]       sym, sym_c;
  logic [10:0]      rank_in;
  logic [CW-1:0]    len;
  logic [BAW-1:0]   x_rd, y_rd;
  logic [AW-1:0]    cnt_b;
  logic [WCW-1:0]   psum;
  logic [CW-1:0]    bj;
  logic             pair_eq, lk_in, rank_ok;

  assign fire    = s_tvalid & s_tready;
  assign ofree   = ~ovalid | m_tready;
  assign sym     = s_tdata[7:0];
  assign rank_in = s_tdata[18:8];
  assign len     = CW'(cnt) + CW'(1);
  assign x_rd    = rk_rd[cur];
  assign y_rd    = rk_rd[~cur];
  assign cnt_b   = built ? '0 : cnt;
  assign psum    = acc + wc_rd;
  assign bj      = CW'(b) + j;
  assign pair_eq = (yb == ya) && ain && bin && (y_rd == yaj);
  assign lk_in   = (i + k < len) && (CW'(q) + k < len);
  assign rank_ok = built && (rank_r != '0) && (RCW'(rank_r) <= RCW'(cnt));

  // clamp symbol codes into 1 .. ALPHABET-1
  always_comb begin
    if (sym == 8'd0) begin
      sym_c = 8'd1;
    end else if ({1'b0, sym} >= 9'(ALPHABET)) begin
      sym_c = 8'(ALPHABET - 1);
    end else begin
      sym_c = sym;
    end
  end

  // memories
  sal_ram #(.DW(8), .DEPTH(DEPTH)) u_tx (
    .clk(clk), .we(tx_we), .wa(tx_wa), .wd(tx_wd), .ra(tx_ra), .rd(tx_rd));
  sal_ram #(.DW(8), .DEPTH(DEPTH)) u_tx2 (
    .clk(clk), .we(tx_we), .wa(tx_wa), .wd(tx_wd), .ra(tx2_ra), .rd(tx2_rd));
  sal_ram #(.DW(AW), .DEPTH(DEPTH)) u_sa (
    .clk(clk), .we(sa_we), .wa(sa_wa), .wd(sa_wd), .ra(sa_ra), .rd(sa_rd));
  sal_ram #(.DW(BAW), .DEPTH(DEPTH)) u_rk0 (
    .clk(clk), .we(rk_we[0]), .wa(rk_wa[0]), .wd(rk_wd[0]), .ra(rk_ra[0]),
    .rd(rk_rd[0]));
  sal_ram #(.DW(BAW), .DEPTH(DEPTH)) u_rk1 (
    .clk(clk), .we(rk_we[1]), .wa(rk_wa[1]), .wd(rk_wd[1]), .ra(rk_ra[1]),
    .rd(rk_rd[1]));
  sal_ram #(.DW(BAW), .DEPTH(DEPTH)) u_wv (
    .clk(clk), .we(wv_we), .wa(wv_wa), .wd(wv_wd), .ra(wv_ra), .rd(wv_rd));
  sal_ram #(.DW(WCW), .DEPTH(BD)) u_wc (
    .clk(clk), .we(wc_we), .wa(wc_wa), .wd(wc_wd), .ra(wc_ra), .rd(wc_rd));
  sal_ram #(.DW(AW), .DEPTH(DEPTH)) u_inv (
    .clk(clk), .we(inv_we), .wa(inv_wa), .wd(inv_wd), .ra(inv_ra),
    .rd(inv_rd));
  sal_ram #(.DW(AW), .DEPTH(DEPTH)) u_lcp (
    .clk(clk), .we(lcp_we), .wa(lcp_wa), .wd(lcp_wd), .ra(lcp_ra),
    .rd(lcp_rd));

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      dropped <= 1'b0;
      built   <= 1'b0;
      ovalid  <= 1'b0;
      cur     <= 1'b0;
      rnd     <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      dropped <= dropped_next;
      built   <= built_next;
      ovalid  <= ovalid_next;
      cur     <= cur_next;
      rnd     <= rnd_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i      <= i_next;
    p      <= p_next;
    m      <= m_next;
    j      <= j_next;
    k      <= k_next;
    acc    <= acc_next;
    key    <= key_next;
    val    <= val_next;
    b      <= b_next;
    yb     <= yb_next;
    ya     <= ya_next;
    yaj    <= yaj_next;
    ain    <= ain_next;
    bin    <= bin_next;
    q      <= q_next;
    invi   <= invi_next;
    rank_r <= rank_r_next;
    okind  <= okind_next;
    ostart <= ostart_next;
    olcp   <= olcp_next;
    olen   <= olen_next;
  end

  // sequencer: next state, RAM ports and output register
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    dropped_next = dropped;
    built_next   = built;
    i_next       = i;
    p_next       = p;
    m_next       = m;
    j_next       = j;
    k_next       = k;
    cur_next     = cur;
    rnd_next     = rnd;
    acc_next     = acc;
    key_next     = key;
    val_next     = val;
    b_next       = b;
    yb_next      = yb;
    ya_next      = ya;
    yaj_next     = yaj;
    ain_next     = ain;
    bin_next     = bin;
    q_next       = q;
    invi_next    = invi;
    rank_r_next  = rank_r;
    ovalid_next  = ovalid & ~m_tready;
    okind_next   = okind;
    ostart_next  = ostart;
    olcp_next    = olcp;
    olen_next    = olen;
    s_tready     = 1'b0;

    tx_we  = 1'b0; tx_wa = '0; tx_wd = '0; tx_ra = '0; tx2_ra = '0;
    sa_we  = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
    rk_we  = 2'b00;
    rk_wa[0] = '0; rk_wa[1] = '0; rk_wd[0] = '0; rk_wd[1] = '0;
    rk_ra[0] = '0; rk_ra[1] = '0;
    wv_we  = 1'b0; wv_wa = '0; wv_wd = '0; wv_ra = '0;
    wc_we  = 1'b0; wc_wa = '0; wc_wd = '0; wc_ra = '0;
    inv_we = 1'b0; inv_wa = '0; inv_wd = '0; inv_ra = '0;
    lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0; lcp_ra = '0;

    case (state)
      // take loads and reads
      ST_IDLE: begin
        s_tready = 1'b1;
        if (fire) begin
          if (s_tuser == FUNC_LOAD) begin
            built_next   = 1'b0;
            dropped_next = built ? 1'b0 : dropped;
            if (CW'(cnt_b) < CW'(MAX_LEN)) begin
              tx_we    = 1'b1;
              tx_wa    = cnt_b;
              tx_wd    = sym_c;
              cnt_next = cnt_b + AW'(1);
            end else begin
              cnt_next     = cnt_b;
              dropped_next = 1'b1;
            end
            if (s_tlast) begin
              state_next = ST_TERM;
            end
          end else begin
            rank_r_next = rank_in;
            state_next  = ST_RDA;
          end
        end
      end
      // append terminator, start initial sort
      ST_TERM: begin
        tx_we      = 1'b1;
        tx_wa      = cnt;
        tx_wd      = 8'd0;
        m_next     = CW'(ALPHABET);
        i_next     = '0;
        rnd_next   = 1'b0;
        cur_next   = 1'b0;
        state_next = ST_CLR;
      end
      // clear bucket counts
      ST_CLR: begin
        wc_we = 1'b1;
        wc_wa = BAW'(i);
        wc_wd = '0;
        if (i == m - CW'(1)) begin
          i_next     = '0;
          state_next = ST_HA;
        end else begin
          i_next = i + CW'(1);
        end
      end
      // histogram of keys
      ST_HA: begin
        tx_ra      = AW'(i);
        wv_ra      = AW'(i);
        state_next = ST_HB;
      end
      ST_HB: begin
        if (rnd) begin
          key_next = wv_rd;
          wc_ra    = wv_rd;
        end else begin
          key_next        = BAW'(tx_rd);
          wc_ra           = BAW'(tx_rd);
          rk_we[cur]      = 1'b1;
          rk_wa[cur]      = AW'(i);
          rk_wd[cur]      = BAW'(tx_rd);
        end
        state_next = ST_HC;
      end
      ST_HC: begin
        wc_we = 1'b1;
        wc_wa = key;
        wc_wd = wc_rd + WCW'(1);
        if (i == len - CW'(1)) begin
          i_next     = '0;
          acc_next   = '0;
          state_next = ST_PSA;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_HA;
        end
      end
      // prefix sum over buckets
      ST_PSA: begin
        wc_ra      = BAW'(i);
        state_next = ST_PSB;
      end
      ST_PSB: begin
        wc_we    = 1'b1;
        wc_wa    = BAW'(i);
        wc_wd    = psum;
        acc_next = psum;
        if (i == m - CW'(1)) begin
          i_next     = len - CW'(1);
          state_next = ST_SCA;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_PSA;
        end
      end
      // scatter from the top down
      ST_SCA: begin
        wv_ra       = AW'(i);
        rk_ra[~cur] = AW'(i);
        rk_ra[cur]  = AW'(i);
        state_next  = ST_SCB;
      end
      ST_SCB: begin
        if (rnd) begin
          key_next = wv_rd;
          wc_ra    = wv_rd;
          val_next = AW'(y_rd);
        end else begin
          key_next = x_rd;
          wc_ra    = x_rd;
          val_next = AW'(i);
        end
        state_next = ST_SCC;
      end
      ST_SCC: begin
        wc_we = 1'b1;
        wc_wa = key;
        wc_wd = wc_rd - WCW'(1);
        sa_we = 1'b1;
        sa_wa = AW'(wc_rd - WCW'(1));
        sa_wd = val;
        if (i == '0) begin
          if (rnd) begin
            cur_next   = ~cur;
            state_next = ST_RKA;
          end else begin
            j_next     = CW'(1);
            p_next     = CW'(1);
            state_next = ST_RND;
          end
        end else begin
          i_next     = i - CW'(1);
          state_next = ST_SCA;
        end
      end
      // start a doubling round or finish
      ST_RND: begin
        if (p < len) begin
          p_next     = '0;
          i_next     = (j < len) ? len - j : '0;
          rnd_next   = 1'b1;
          state_next = ST_Y1;
        end else begin
          i_next     = CW'(1);
          state_next = ST_INVA;
        end
      end
      // second-key order: tail suffixes first
      ST_Y1: begin
        if (i < len) begin
          rk_we[~cur] = 1'b1;
          rk_wa[~cur] = AW'(p);
          rk_wd[~cur] = BAW'(i);
          p_next      = p + CW'(1);
          i_next      = i + CW'(1);
        end else begin
          i_next     = '0;
          state_next = ST_Y2A;
        end
      end
      ST_Y2A: begin
        sa_ra      = AW'(i);
        state_next = ST_Y2B;
      end
      ST_Y2B: begin
        if (CW'(sa_rd) >= j) begin
          rk_we[~cur] = 1'b1;
          rk_wa[~cur] = AW'(p);
          rk_wd[~cur] = BAW'(CW'(sa_rd) - j);
          p_next      = p + CW'(1);
        end
        if (i == len - CW'(1)) begin
          i_next     = '0;
          state_next = ST_WVA;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_Y2A;
        end
      end
      // gather first keys in second-key order
      ST_WVA: begin
        rk_ra[~cur] = AW'(i);
        state_next  = ST_WVB;
      end
      ST_WVB: begin
        rk_ra[cur] = AW'(y_rd);
        state_next = ST_WVC;
      end
      ST_WVC: begin
        wv_we = 1'b1;
        wv_wa = AW'(i);
        wv_wd = x_rd;
        if (i == len - CW'(1)) begin
          i_next     = '0;
          state_next = ST_CLR;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_WVA;
        end
      end
      // re-rank in sorted order
      ST_RKA: begin
        sa_ra      = AW'(i);
        state_next = ST_RKB;
      end
      ST_RKB: begin
        b_next      = sa_rd;
        rk_ra[~cur] = sa_rd;
        state_next  = ST_RKC;
      end
      ST_RKC: begin
        yb_next     = y_rd;
        bin_next    = bj < len;
        rk_ra[~cur] = AW'(bj);
        state_next  = ST_RKD;
      end
      ST_RKD: begin
        rk_we[cur] = 1'b1;
        rk_wa[cur] = b;
        if (i == '0) begin
          rk_wd[cur] = '0;
          p_next     = CW'(1);
        end else if (pair_eq) begin
          rk_wd[cur] = BAW'(p - CW'(1));
        end else begin
          rk_wd[cur] = BAW'(p);
          p_next     = p + CW'(1);
        end
        ya_next  = yb;
        yaj_next = y_rd;
        ain_next = bin;
        if (i == len - CW'(1)) begin
          j_next     = j << 1;
          m_next     = p_next;
          state_next = ST_RND;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_RKA;
        end
      end
      // inverse of the suffix array
      ST_INVA: begin
        sa_ra      = AW'(i);
        state_next = ST_INVB;
      end
      ST_INVB: begin
        inv_we = 1'b1;
        inv_wa = sa_rd;
        inv_wd = AW'(i);
        if (i == CW'(cnt)) begin
          i_next     = '0;
          k_next     = '0;
          state_next = ST_LKA;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_INVA;
        end
      end
      // Kasai height pass
      ST_LKA: begin
        if (k != '0) begin
          k_next = k - CW'(1);
        end
        inv_ra     = AW'(i);
        state_next = ST_LKB;
      end
      ST_LKB: begin
        invi_next  = inv_rd;
        sa_ra      = inv_rd - AW'(1);
        state_next = ST_LKC;
      end
      ST_LKC: begin
        q_next     = sa_rd;
        tx_ra      = AW'(i + k);
        tx2_ra     = AW'(CW'(sa_rd) + k);
        state_next = ST_LKD;
      end
      ST_LKD: begin
        if (lk_in && (tx_rd == tx2_rd)) begin
          k_next = k + CW'(1);
          tx_ra  = AW'(i + k + CW'(1));
          tx2_ra = AW'(CW'(q) + k + CW'(1));
        end else begin
          lcp_we = 1'b1;
          lcp_wa = invi;
          lcp_wd = AW'(k);
          if (i == CW'(cnt) - CW'(1)) begin
            state_next = ST_DONE;
          end else begin
            i_next     = i + CW'(1);
            state_next = ST_LKA;
          end
        end
      end
      // report the build
      ST_DONE: begin
        if (ofree) begin
          ovalid_next = 1'b1;
          okind_next  = dropped ? KIND_TRUNC : KIND_BUILT;
          ostart_next = '0;
          olcp_next   = '0;
          olen_next   = 11'(cnt);
          built_next  = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      // answer a rank read
      ST_RDA: begin
        sa_ra      = AW'(rank_r);
        lcp_ra     = AW'(rank_r);
        state_next = ST_RDB;
      end
      ST_RDB: begin
        sa_ra  = AW'(rank_r);
        lcp_ra = AW'(rank_r);
        if (ofree) begin
          ovalid_next = 1'b1;
          okind_next  = rank_ok ? KIND_RANK : KIND_BAD;
          ostart_next = rank_ok ? 10'(sa_rd) : '0;
          olcp_next   = rank_ok ? 10'(lcp_rd) : '0;
          olen_next   = 11'(cnt);
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = ovalid;
  assign m_tuser  = okind;
  assign m_tdata  = {1'b0, olen, olcp, ostart};

  // a rank answer always comes with a nonempty text
  a_rank_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_RANK) |-> (m_tdata[30:20] != '0))
    else $error("rank answer with empty text");

  // the symbol count never passes MAX_LEN
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    CW'(cnt) <= CW'(MAX_LEN))
    else $error("symbol count over limit");

  // ranks handed out never exceed the number of suffixes seen
  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RKD && i != '0) |-> (p <= i))
    else $error("rank counter ran ahead");

  // the end of a build loads a build report into the result register
  a_done_report: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && ofree) |=>
      (m_tvalid && (m_tuser == KIND_BUILT || m_tuser == KIND_TRUNC) && built))
    else $error("build report missing");

  // no input is taken in the re-rank, Kasai and report states
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RKD || state == ST_LKD || state == ST_DONE) |-> !s_tready)
    else $error("input accepted during build");

endmodule

`default_nettype wire

// ===== tb/sv/tb_suffix_array_lcp_builder.sv =====
// ----------------------------------------------------------------------------
// tb_suffix_array_lcp_builder: self-checking bench for the suffix array builder
// Loads strings one symbol per item, reads ranks of each string back, and compares each
// result item against a local prefix-doubling and Kasai computation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_suffix_array_lcp_builder;
  import sal_pkg::*;

  localparam int MAXN      = 1024;
  localparam int KEYS      = 1400;
  localparam int IDLE_MAX  = 600000;
  localparam int ITEMS     = 850;
  localparam int LONG_LEN  = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [9:0]  start;
    logic [9:0]  lcp;
    logic [10:0] tlen;
  } sa_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // symbol[7:0], rank[18:8], zero pad
  logic        s_tuser = 1'b0; // func
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // suffix_start[9:0], lcp_length[19:10], text_length[30:20]
  logic [1:0]  m_tuser;        // kind

  suffix_array_lcp_builder u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [7:0]  text_mem [0:MAXN];
  int          sym_count;
  bit          is_built;
  bit          overflow;
  int          order_mem [0:MAXN];
  int          height_mem [0:MAXN];
  int          class_id [0:MAXN];
  int          next_key [0:MAXN];
  int          tmp_ord [0:MAXN];
  int          bucket [0:KEYS-1];
  sa_result_t  pending [$];

  int  errors = 0;
  int  items_sent = 0;
  bit  no_gaps = 1'b0;
  bit  rx_hold = 1'b0;

  // stable counting sort of order_mem by class_id (sel 1) or next_key (sel 0)
  task automatic sort_by(input bit sel, input int len);
    int i, kv;
    for (i = 0; i < KEYS; i++) bucket[i] = 0;
    for (i = 0; i < len; i++) begin
      kv = sel ? class_id[order_mem[i]] : next_key[order_mem[i]];
      bucket[kv]++;
    end
    for (i = 1; i < KEYS; i++) bucket[i] += bucket[i-1];
    for (i = len - 1; i >= 0; i--) begin
      kv = sel ? class_id[order_mem[i]] : next_key[order_mem[i]];
      bucket[kv]--;
      tmp_ord[bucket[kv]] = order_mem[i];
    end
    for (i = 0; i < len; i++) order_mem[i] = tmp_ord[i];
  endtask

  // suffix array by rank doubling, then LCP heights by Kasai
  task automatic build_suffixes();
    int len, span, i, a, b, classes, h, q;
    int inv [0:MAXN];
    len = sym_count + 1;
    text_mem[sym_count] = 8'd0;
    for (i = 0; i < len; i++) class_id[i] = text_mem[i];
    span = 1;
    forever begin
      for (i = 0; i < len; i++) begin
        next_key[i] = (i + span < len) ? class_id[i+span] + 1 : 0;
        order_mem[i] = i;
      end
      sort_by(1'b0, len);
      sort_by(1'b1, len);
      classes = 0;
      tmp_ord[order_mem[0]] = 0;
      for (i = 1; i < len; i++) begin
        a = order_mem[i-1];
        b = order_mem[i];
        if (class_id[a] != class_id[b] || next_key[a] != next_key[b]) classes++;
        tmp_ord[b] = classes;
      end
      for (i = 0; i < len; i++) class_id[i] = tmp_ord[i];
      if (classes == len - 1) break;
      span *= 2;
    end
    for (i = 0; i < len; i++) inv[order_mem[i]] = i;
    h = 0;
    for (i = 0; i < sym_count; i++) begin
      if (h > 0) h--;
      q = order_mem[inv[i]-1];
      while (i + h < len && q + h < len && text_mem[i+h] == text_mem[q+h]) h++;
      height_mem[inv[i]] = h;
    end
    is_built = 1'b1;
  endtask

  // update the predictor with one accepted item and queue its result
  task automatic predict_item(input logic func, input logic [7:0] sym, input logic last,
                              input logic [10:0] rank);
    sa_result_t r;
    logic [7:0] code;
    r = '{kind: KIND_BAD, start: '0, lcp: '0, tlen: '0};
    if (func == FUNC_LOAD) begin
      if (is_built) begin
        is_built = 1'b0;
        sym_count = 0;
        overflow = 1'b0;
      end
      code = (sym == 8'd0) ? 8'd1 : sym;
      if (sym_count < MAXN) begin
        text_mem[sym_count] = code;
        sym_count++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;
      build_suffixes();
      r.kind = overflow ? KIND_TRUNC : KIND_BUILT;
      r.tlen = sym_count[10:0];
    end else begin
      r.tlen = sym_count[10:0];
      if (is_built && rank != 0 && rank <= sym_count) begin
        r.kind  = KIND_RANK;
        r.start = order_mem[rank][9:0];
        r.lcp   = height_mem[rank][9:0];
      end
    end
    pending.push_back(r);
  endtask

  // offer one item, hold it until taken, then predict
  task automatic send_item(input logic func, input logic [7:0] sym, input logic last,
                           input logic [10:0] rank);
    while (!no_gaps && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tlast  <= last;
    s_tdata  <= {5'b0, rank, sym};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    predict_item(func, sym, last, rank);
  endtask

  task automatic load_string(input int len, input int lo, input int hi);
    int i;
    for (i = 0; i < len; i++)
      send_item(FUNC_LOAD, 8'($urandom_range(hi, lo)), i == len - 1, 11'd0);
  endtask

  task automatic read_all_ranks(input int n);
    int r;
    for (r = 1; r <= n; r++) send_item(FUNC_READ, 8'($urandom), 1'b0, 11'(r));
  endtask

  // reads before any build, then tiny strings and edge symbol codes
  task automatic test_small_strings();
    send_item(FUNC_READ, 8'd0, 1'b0, 11'd1);
    send_item(FUNC_LOAD, 8'd255, 1'b1, 11'd0);
    send_item(FUNC_READ, 8'd0, 1'b0, 11'd0);
    send_item(FUNC_READ, 8'd0, 1'b0, 11'd1);
    send_item(FUNC_READ, 8'd0, 1'b0, 11'd2);
    send_item(FUNC_LOAD, 8'd0, 1'b0, 11'd2047);
    send_item(FUNC_READ, 8'd0, 1'b0, 11'd1);
    send_item(FUNC_LOAD, 8'd1, 1'b0, 11'd0);
    send_item(FUNC_LOAD, 8'd255, 1'b0, 11'd0);
    send_item(FUNC_LOAD, 8'd0, 1'b1, 11'd0);
    read_all_ranks(4);
    send_item(FUNC_READ, 8'd255, 1'b0, 11'd5);
    send_item(FUNC_READ, 8'd255, 1'b0, 11'd2047);
  endtask

  // let results back up while reads keep coming
  task automatic test_receiver_stall();
    load_string(12, 1, 2);
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    read_all_ranks(12);
  endtask

  // long repetitive string needing many rounds, read its edge ranks; no idling
  task automatic test_long_string();
    int i;
    no_gaps = 1'b1;
    for (i = 0; i < LONG_LEN; i++)
      send_item(FUNC_LOAD, (i % 7 == 3) ? 8'd2 : 8'd1, i == LONG_LEN - 1, 11'd0);
    send_item(FUNC_READ, 8'd0, 1'b0, 11'd1);
    send_item(FUNC_READ, 8'd0, 1'b0, 11'(LONG_LEN));
    send_item(FUNC_READ, 8'd0, 1'b0, 11'(LONG_LEN + 1));
    send_item(FUNC_READ, 8'd0, 1'b0, 11'd2047);
    for (i = 0; i < 8; i++)
      send_item(FUNC_READ, 8'd0, 1'b0, 11'($urandom_range(LONG_LEN, 1)));
    no_gaps = 1'b0;
    // a shorter string over the full symbol range
    load_string(120, 1, 255);
    for (i = 0; i < 6; i++) send_item(FUNC_READ, 8'd0, 1'b0, 11'($urandom_range(120, 1)));
  endtask

  // random strings, mostly short, each followed by reads of its ranks
  task automatic test_random_strings();
    int n, i, hi, r;
    while (items_sent < ITEMS) begin
      n  = ($urandom_range(9) == 0) ? $urandom_range(150, 30) : $urandom_range(24, 1);
      hi = ($urandom_range(3) == 0) ? 255 : $urandom_range(4, 2);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0)
          send_item(FUNC_READ, 8'($urandom), 1'b0, 11'($urandom_range(3)));
        send_item(FUNC_LOAD, ($urandom_range(49) == 0) ? 8'd0 : 8'($urandom_range(hi, 1)),
                  i == n - 1, 11'($urandom));
      end
      for (i = 0; i < ((n < 24) ? n + 2 : 24); i++) begin
        case ($urandom_range(9))
          0:       r = 0;
          1:       r = $urandom_range(2047, n + 1);
          default: r = $urandom_range(n, 1);
        endcase
        send_item(FUNC_READ, 8'($urandom), 1'b0, 11'(r));
      end
    end
  endtask

  // receiver ready with random stalls
  always @(posedge clk) begin
    if (rx_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= 36);
    end
  end

  // compare each taken result with the oldest prediction
  always @(negedge clk) begin
    sa_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d data=%h", m_tuser, m_tdata);
        errors++;
      end else begin
        e = pending.pop_front();
        if (m_tuser !== e.kind) begin
          $error("kind expected %0d got %0d", e.kind, m_tuser);
          errors++;
        end
        if (m_tdata[9:0] !== e.start) begin
          $error("suffix_start expected %0d got %0d", e.start, m_tdata[9:0]);
          errors++;
        end
        if (m_tdata[19:10] !== e.lcp) begin
          $error("lcp_length expected %0d got %0d", e.lcp, m_tdata[19:10]);
          errors++;
        end
        if (m_tdata[30:20] !== e.tlen) begin
          $error("text_length expected %0d got %0d", e.tlen, m_tdata[30:20]);
          errors++;
        end
      end
    end
  end

  // end the run after too long without any handshake
  int idle_cycles = 0;
  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sym_count = 0;
    is_built  = 1'b0;
    overflow  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_strings();
    test_receiver_stall();
    test_long_string();
    test_random_strings();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
